[src/hfn_pkg.sv]
`timescale 1ns / 1ps
package hfn_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MOD,
        ST_WR,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_DIFF,
        ST_SQA,
        ST_SQB,
        ST_SQD,
        ST_SUM,
        ST_CSEL,
        ST_CWAIT,
        ST_FIN
    } t_state;

    typedef enum logic [1:0] {
        QS_IDLE,
        QS_DIV,
        QS_SQRT
    } t_qstate;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic CFG_SIDE    = 1'b0;
    localparam logic CFG_SPACING = 1'b1;

    localparam int COORD_W   = 8;
    localparam int HEIGHT_W  = 16;
    localparam int NORM_W    = 16;
    localparam int SIDE_W    = 9;
    localparam int SPACING_W = 16;

    localparam logic [SIDE_W-1:0]    SIDE_MIN      = 9'd2;
    localparam logic [SIDE_W-1:0]    SIDE_RESET    = 9'd256;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd256;

    localparam int QUO_W     = 30;
    localparam int ROOT_W    = 15;
    localparam logic [4:0] DIV_LAST  = 5'd29;
    localparam logic [4:0] ROOT_LAST = 5'd14;

    localparam logic [NORM_W-1:0] Q_ONE = 16'h8000;
    localparam logic [NORM_W-1:0] Q_MAX = 16'h7FFF;

endpackage

[src/hfn_ram.sv]
`timescale 1ns / 1ps
module hfn_ram #(
    parameter int AW = 16,
    parameter int DW = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_addr,
    input  logic [DW-1:0] i_wdata,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/hfn_qunit.sv]
`timescale 1ns / 1ps
module hfn_qunit #(
    parameter int SW = 34
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [SW-1:0]                i_sq,
    input  logic [SW-1:0]                i_s,
    output logic                         o_done,
    output logic [hfn_pkg::ROOT_W-1:0]   o_q
);

    hfn_pkg::t_qstate r_state, n_state;
    logic [4:0]                   r_cnt;
    logic [SW-1:0]                r_rem;
    logic [SW-1:0]                r_s;
    logic [hfn_pkg::QUO_W-1:0]    r_quo;
    logic [hfn_pkg::ROOT_W-1:0]   r_root;
    logic                         r_done;

    logic [SW:0]                  rem2;
    logic                         ge;
    logic [hfn_pkg::ROOT_W-1:0]   trial;
    logic [hfn_pkg::QUO_W-1:0]    sqr;
    logic                         last;

    assign rem2  = {r_rem, 1'b0};
    assign ge    = rem2 >= {1'b0, r_s};
    assign trial = r_root | (hfn_pkg::ROOT_W'(1) << r_cnt[3:0]);
    assign sqr   = hfn_pkg::QUO_W'(trial) * hfn_pkg::QUO_W'(trial);
    assign last  = (r_cnt == 5'd0);

    always_comb begin
        n_state = r_state;
        case (r_state)
            hfn_pkg::QS_IDLE: begin
                if (i_start) n_state = hfn_pkg::QS_DIV;
            end
            hfn_pkg::QS_DIV: begin
                if (last) n_state = hfn_pkg::QS_SQRT;
            end
            hfn_pkg::QS_SQRT: begin
                if (last) n_state = hfn_pkg::QS_IDLE;
            end
            default: n_state = hfn_pkg::QS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hfn_pkg::QS_IDLE;
            r_cnt   <= 5'd0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == hfn_pkg::QS_SQRT) && last;
            case (r_state)
                hfn_pkg::QS_IDLE: r_cnt <= hfn_pkg::DIV_LAST;
                hfn_pkg::QS_DIV:  r_cnt <= last ? hfn_pkg::ROOT_LAST : r_cnt - 5'd1;
                hfn_pkg::QS_SQRT: r_cnt <= r_cnt - 5'd1;
                default:          r_cnt <= 5'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            hfn_pkg::QS_IDLE: begin
                r_rem  <= i_sq;
                r_s    <= i_s;
                r_root <= '0;
            end
            hfn_pkg::QS_DIV: begin
                r_rem <= ge ? SW'(rem2 - {1'b0, r_s}) : SW'(rem2);
                r_quo <= {r_quo[hfn_pkg::QUO_W-2:0], ge};
            end
            hfn_pkg::QS_SQRT: begin
                if (sqr <= r_quo) r_root <= trial;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_q    = r_root;

endmodule

[src/height_field_normal_unit_top.sv]
`timescale 1ns / 1ps
// Height field surface normal unit.
// The input stream carries one item per command: s_tuser is the command
// (write height or query normal), s_tdata holds row, column and height.
// A write stores one signed height and gives no result. A query gives one
// output item on the m_ channel with the unit normal as three Q1.15 words.
// Items are taken one at a time; s_tready is high only while the unit waits.
// A write first does the row and column reduction by the side in use and
// then the memory write.
// A query does the same reduction, three reads of the single height memory
// port, three squarings on one shared multiplier, and for each of the three
// components a 30 step divider and a 15 step square root in one shared
// iterative unit, unless the square of that component alone reaches the
// sum. A flat query with zero spacing skips that unit.
// The result sits in an output register; while the receiver stalls, the
// unit still accepts the next item and only a second result waits for it.
// Reset empties the output register and sets the side to 256 and the
// spacing to 1.0; the heights are not cleared and must be written before
// they are queried. The user must write configuration through i_cfg_we
// only while the unit is idle; the unit itself does not enforce this.
module height_field_normal_unit_top #(
    parameter int MAX_SIDE    = 256,
    parameter int HEIGHT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // row [7:0], col [15:8], height [31:16]
    input  logic        s_tuser,   // cmd [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // normal_x [15:0], normal_y [31:16], normal_z [47:32]
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CW   = $clog2(MAX_SIDE);
    localparam int AW   = 2 * CW;
    localparam int HB   = HEIGHT_BITS;
    localparam int MW   = (HB + 1 > hfn_pkg::SPACING_W) ? HB + 1 : hfn_pkg::SPACING_W;
    localparam int SQ_W = 2 * MW;
    localparam int SW   = SQ_W + 2;

    hfn_pkg::t_state r_state, n_state;

    logic [hfn_pkg::SIDE_W-1:0]    r_side;
    logic [hfn_pkg::SPACING_W-1:0] r_spacing;

    logic                          r_cmd;
    logic [7:0]                    r_row8, r_col8;
    logic signed [15:0]            r_height;
    logic [7:0]                    r_rrem, r_crem;
    logic [2:0]                    r_cnt;
    logic [hfn_pkg::SIDE_W-1:0]    r_n;
    logic signed [HB-1:0]          r_h0, r_hn, r_hp;
    logic signed [HB:0]            r_a, r_b;
    logic [SQ_W-1:0]               r_pa, r_pb, r_pd;
    logic [SW-1:0]                 r_s;
    logic                          r_flat;
    logic [1:0]                    r_comp;
    logic [15:0]                   r_qx, r_qy, r_qz;
    logic                          r_out_valid;
    logic [47:0]                   r_out_data;

    logic                          in_acc;
    logic [hfn_pkg::SIDE_W-1:0]    side_eff;
    logic [8:0]                    rr_sh, cr_sh;
    logic                          rr_ge, cr_ge;
    logic [8:0]                    row9, col9, rn9, cp9;
    logic [8:0]                    ram_row, ram_col;
    logic                          ram_we;
    logic [AW-1:0]                 ram_addr;
    logic [HB-1:0]                 ram_rdata;
    logic [HB:0]                   mag_a, mag_b;
    logic [MW-1:0]                 mul_op;
    logic [SQ_W-1:0]               mul_p;
    logic [SW-1:0]                 sel_sq;
    logic                          sq_ge;
    logic                          q_start, q_done;
    logic [hfn_pkg::ROOT_W-1:0]    q_root;
    logic                          comp_fin;
    logic                          out_load;
    logic                          neg_x, neg_z;

    function automatic logic [15:0] fin_q(input logic neg, input logic [15:0] q);
        logic [15:0] v;
        if (neg) begin
            v = 16'(0) - q;
        end else if (q > hfn_pkg::Q_MAX) begin
            v = hfn_pkg::Q_MAX;
        end else begin
            v = q;
        end
        return v;
    endfunction

    assign in_acc   = s_tvalid && s_tready;
    assign s_tready = (r_state == hfn_pkg::ST_IDLE);

    assign side_eff = (r_side < hfn_pkg::SIDE_MIN) ? hfn_pkg::SIDE_MIN :
                      ((32'(r_side) > MAX_SIDE) ? hfn_pkg::SIDE_W'(MAX_SIDE) : r_side);

    assign rr_sh = {r_rrem, r_row8[r_cnt]};
    assign cr_sh = {r_crem, r_col8[r_cnt]};
    assign rr_ge = rr_sh >= r_n;
    assign cr_ge = cr_sh >= r_n;

    assign row9 = {1'b0, r_rrem};
    assign col9 = {1'b0, r_crem};
    assign rn9  = (row9 + 9'd1 == r_n) ? 9'd0 : row9 + 9'd1;
    assign cp9  = (col9 == 9'd0) ? r_n - 9'd1 : col9 - 9'd1;

    assign ram_row  = (r_state == hfn_pkg::ST_RD1) ? rn9 : row9;
    assign ram_col  = (r_state == hfn_pkg::ST_RD2) ? cp9 : col9;
    assign ram_addr = {CW'(ram_row), CW'(ram_col)};
    assign ram_we   = (r_state == hfn_pkg::ST_WR);

    hfn_ram #(
        .AW(AW),
        .DW(HB)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(HB'(r_height)),
        .o_rdata(ram_rdata)
    );

    assign mag_a = r_a[HB] ? (HB+1)'(-r_a) : r_a;
    assign mag_b = r_b[HB] ? (HB+1)'(-r_b) : r_b;

    always_comb begin
        case (r_state)
            hfn_pkg::ST_SQA: mul_op = MW'(mag_a);
            hfn_pkg::ST_SQB: mul_op = MW'(mag_b);
            default:         mul_op = MW'(r_spacing);
        endcase
    end
    assign mul_p = SQ_W'(mul_op) * SQ_W'(mul_op);

    always_comb begin
        case (r_comp)
            2'd0:    sel_sq = SW'(r_pa);
            2'd1:    sel_sq = SW'(r_pd);
            default: sel_sq = SW'(r_pb);
        endcase
    end
    assign sq_ge = sel_sq >= r_s;

    hfn_qunit #(
        .SW(SW)
    ) u_qunit (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(q_start),
        .i_sq   (sel_sq),
        .i_s    (r_s),
        .o_done (q_done),
        .o_q    (q_root)
    );

    assign neg_x = !r_a[HB] && (r_a != '0);
    assign neg_z = r_b[HB];

    always_comb begin
        n_state  = r_state;
        q_start  = 1'b0;
        comp_fin = 1'b0;
        out_load = 1'b0;
        case (r_state)
            hfn_pkg::ST_IDLE: begin
                if (in_acc) n_state = hfn_pkg::ST_MOD;
            end
            hfn_pkg::ST_MOD: begin
                if (r_cnt == 3'd0) begin
                    n_state = (r_cmd == hfn_pkg::CMD_WRITE) ? hfn_pkg::ST_WR : hfn_pkg::ST_RD0;
                end
            end
            hfn_pkg::ST_WR:   n_state = hfn_pkg::ST_IDLE;
            hfn_pkg::ST_RD0:  n_state = hfn_pkg::ST_RD1;
            hfn_pkg::ST_RD1:  n_state = hfn_pkg::ST_RD2;
            hfn_pkg::ST_RD2:  n_state = hfn_pkg::ST_RD3;
            hfn_pkg::ST_RD3:  n_state = hfn_pkg::ST_DIFF;
            hfn_pkg::ST_DIFF: n_state = hfn_pkg::ST_SQA;
            hfn_pkg::ST_SQA:  n_state = hfn_pkg::ST_SQB;
            hfn_pkg::ST_SQB:  n_state = hfn_pkg::ST_SQD;
            hfn_pkg::ST_SQD:  n_state = hfn_pkg::ST_SUM;
            hfn_pkg::ST_SUM:  n_state = hfn_pkg::ST_CSEL;
            hfn_pkg::ST_CSEL: begin
                if (r_flat) begin
                    n_state = hfn_pkg::ST_FIN;
                end else if (sq_ge) begin
                    comp_fin = 1'b1;
                    n_state  = (r_comp == 2'd2) ? hfn_pkg::ST_FIN : hfn_pkg::ST_CSEL;
                end else begin
                    q_start = 1'b1;
                    n_state = hfn_pkg::ST_CWAIT;
                end
            end
            hfn_pkg::ST_CWAIT: begin
                if (q_done) begin
                    comp_fin = 1'b1;
                    n_state  = (r_comp == 2'd2) ? hfn_pkg::ST_FIN : hfn_pkg::ST_CSEL;
                end
            end
            hfn_pkg::ST_FIN: begin
                if (!r_out_valid || m_tready) begin
                    out_load = 1'b1;
                    n_state  = hfn_pkg::ST_IDLE;
                end
            end
            default: n_state = hfn_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hfn_pkg::ST_IDLE;
            r_side      <= hfn_pkg::SIDE_RESET;
            r_spacing   <= hfn_pkg::SPACING_RESET;
            r_out_valid <= 1'b0;
            r_cnt       <= 3'd0;
            r_comp      <= 2'd0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hfn_pkg::CFG_SIDE:    r_side    <= i_cfg_data[hfn_pkg::SIDE_W-1:0];
                    hfn_pkg::CFG_SPACING: r_spacing <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_cnt <= 3'd7;
            end else if (r_state == hfn_pkg::ST_MOD) begin
                r_cnt <= r_cnt - 3'd1;
            end
            if (r_state == hfn_pkg::ST_SUM) begin
                r_comp <= 2'd0;
            end else if (comp_fin) begin
                r_comp <= r_comp + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            hfn_pkg::ST_IDLE: begin
                r_cmd    <= s_tuser;
                r_row8   <= s_tdata[7:0];
                r_col8   <= s_tdata[15:8];
                r_height <= s_tdata[31:16];
                r_n      <= side_eff;
                r_rrem   <= 8'd0;
                r_crem   <= 8'd0;
            end
            hfn_pkg::ST_MOD: begin
                r_rrem <= rr_ge ? 8'(rr_sh - r_n) : rr_sh[7:0];
                r_crem <= cr_ge ? 8'(cr_sh - r_n) : cr_sh[7:0];
            end
            hfn_pkg::ST_RD1: r_h0 <= ram_rdata;
            hfn_pkg::ST_RD2: r_hn <= ram_rdata;
            hfn_pkg::ST_RD3: r_hp <= ram_rdata;
            hfn_pkg::ST_DIFF: begin
                r_a <= (HB+1)'(r_hn) - (HB+1)'(r_h0);
                r_b <= (HB+1)'(r_hp) - (HB+1)'(r_h0);
            end
            hfn_pkg::ST_SQA: r_pa <= mul_p;
            hfn_pkg::ST_SQB: r_pb <= mul_p;
            hfn_pkg::ST_SQD: r_pd <= mul_p;
            hfn_pkg::ST_SUM: begin
                r_s    <= SW'(r_pa) + SW'(r_pb) + SW'(r_pd);
                r_flat <= (r_pa == '0) && (r_pb == '0) && (r_pd == '0);
            end
            default: ;
        endcase
        if (comp_fin) begin
            case (r_comp)
                2'd0:    r_qx <= sq_ge && (r_state == hfn_pkg::ST_CSEL) ? hfn_pkg::Q_ONE
                                                                        : 16'(q_root);
                2'd1:    r_qy <= sq_ge && (r_state == hfn_pkg::ST_CSEL) ? hfn_pkg::Q_ONE
                                                                        : 16'(q_root);
                default: r_qz <= sq_ge && (r_state == hfn_pkg::ST_CSEL) ? hfn_pkg::Q_ONE
                                                                        : 16'(q_root);
            endcase
        end
        if (out_load) begin
            if (r_flat) begin
                r_out_data <= {16'd0, hfn_pkg::Q_MAX, 16'd0};
            end else begin
                r_out_data <= {fin_q(neg_z, r_qz), fin_q(1'b0, r_qy), fin_q(neg_x, r_qx)};
            end
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

[src/hfn_checker.sv]
`timescale 1ns / 1ps
module hfn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("Output item changed or dropped while stalled.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Input taken again while an item is in work.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("Output valid after reset.");

    a_up_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> !m_tdata[31])
        else $error("Up component of the normal is negative.");

endmodule

bind height_field_normal_unit_top hfn_checker u_hfn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
);
